// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL. Each use sits on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A plain property, checked at every rising edge outside reset.
`define TUN_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("tun assertion failed");

// An implication in the same cycle.
`define TUN_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tun implication failed");

`endif

// ===== rtl/tun_pkg.sv =====
package tun_pkg;

	localparam int COORD_WIDTH      = 16;
	localparam int NORMAL_FRAC_BITS = 14;
	localparam int EDGE_W  = COORD_WIDTH + 1;
	localparam int PROD_W  = 2 * EDGE_W;
	localparam int CROSS_W = PROD_W + 1;
	localparam int MAG_W   = CROSS_W - 1;
	localparam int SQ_W    = 2 * MAG_W;
	localparam int SUM_W   = SQ_W + 2;
	localparam int ROOT_W  = SUM_W / 2;
	localparam int REM_W   = ROOT_W + 2;
	localparam int DREM_W  = ROOT_W + 1;
	localparam int QUOT_W  = NORMAL_FRAC_BITS + 1;
	localparam int OUT_W   = NORMAL_FRAC_BITS + 2;
	localparam logic signed [OUT_W-1:0] LIMIT = OUT_W'(1) <<< NORMAL_FRAC_BITS;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] p1_x;
		logic signed [COORD_WIDTH-1:0] p1_y;
		logic signed [COORD_WIDTH-1:0] p1_z;
		logic signed [COORD_WIDTH-1:0] p2_x;
		logic signed [COORD_WIDTH-1:0] p2_y;
		logic signed [COORD_WIDTH-1:0] p2_z;
		logic signed [COORD_WIDTH-1:0] p3_x;
		logic signed [COORD_WIDTH-1:0] p3_y;
		logic signed [COORD_WIDTH-1:0] p3_z;
	} in_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] normal_x;
		logic signed [OUT_W-1:0] normal_y;
		logic signed [OUT_W-1:0] normal_z;
		logic                    degenerate;
	} out_t;

	// Per-component magnitudes and signs that ride alongside the root.
	typedef struct packed {
		logic [2:0][MAG_W-1:0] mag;
		logic [2:0]            neg;
		logic                  degen;
	} side_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] value;
		logic                    zero;
	} lane_t;

endpackage

// ===== rtl/triangle_unit_normal_top.sv =====
// Unit normal of a triangle given as three signed Q8.8 vertices, returned as
// signed Q1.14 components with a flag for a zero cross product (normal then
// zero). One transaction is accepted per cycle while no result waits under
// stall; each result passes through the edge, cross product and squared length
// stages, the square root at one root bit a stage, the division at
// one quotient bit a stage and one output register. The whole pipeline holds
// while a result waits under stall.
`include "assert_macros.svh"

module triangle_unit_normal_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vtx_valid,
	output logic          vtx_stall,
	input  tun_pkg::in_t  vtx,
	output logic          nrm_valid,
	input  logic          nrm_stall,
	output tun_pkg::out_t nrm
);
	import tun_pkg::*;

	logic              en;
	logic              front_v, sqrt_v;
	logic [SUM_W-1:0]  sum;
	side_t             front_side, sqrt_side;
	logic [ROOT_W-1:0] root;
	logic [2:0]        lane_v;
	lane_t             lane [3];

	assign en        = !(nrm_valid && nrm_stall);
	assign vtx_stall = !en;

	tun_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vtx_valid),
		.vtx      (vtx),
		.out_valid(front_v),
		.sum      (sum),
		.side     (front_side)
	);

	tun_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (front_v),
		.sum      (sum),
		.side_in  (front_side),
		.out_valid(sqrt_v),
		.root     (root),
		.side_out (sqrt_side)
	);

	for (genvar i = 0; i < 3; i++) begin : g_lane
		tun_div u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (sqrt_v),
			.root     (root),
			.mag      (sqrt_side.mag[i]),
			.neg      (sqrt_side.neg[i]),
			.zero     (sqrt_side.degen),
			.out_valid(lane_v[i]),
			.lane     (lane[i])
		);
	end

	assign nrm_valid      = lane_v[0];
	assign nrm.normal_x   = lane[0].value;
	assign nrm.normal_y   = lane[1].value;
	assign nrm.normal_z   = lane[2].value;
	assign nrm.degenerate = lane[0].zero;

	`TUN_ASSERT(a_lanes_aligned, lane_v[0] == lane_v[1] && lane_v[0] == lane_v[2])
	`TUN_ASSERT_IMP(a_degen_zero, nrm_valid && nrm.degenerate, nrm.normal_x == '0 && nrm.normal_y == '0 && nrm.normal_z == '0)
	`TUN_ASSERT_IMP(a_bound, nrm_valid, nrm.normal_x <= LIMIT && nrm.normal_x >= -LIMIT && nrm.normal_y <= LIMIT && nrm.normal_y >= -LIMIT && nrm.normal_z <= LIMIT && nrm.normal_z >= -LIMIT)
	`TUN_ASSERT_IMP(a_stall_cause, vtx_stall, nrm_valid && nrm_stall)

endmodule

// ===== rtl/tun_front.sv =====
module tun_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  tun_pkg::in_t   vtx,
	output logic           out_valid,
	output logic [tun_pkg::SUM_W-1:0] sum,
	output tun_pkg::side_t side
);
	import tun_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic signed [EDGE_W-1:0]  a0_s1, a1_s1, a2_s1, b0_s1, b1_s1, b2_s1;
	logic signed [PROD_W-1:0]  m0_s2, m1_s2, m2_s2, m3_s2, m4_s2, m5_s2;
	logic signed [CROSS_W-1:0] c0_s3, c1_s3, c2_s3;
	side_t                     side_s4, side_s5, side_s6;
	logic [SQ_W-1:0]           sq0_s5, sq1_s5, sq2_s5;
	logic [SUM_W-1:0]          sum_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a0_s1 <= EDGE_W'(vtx.p1_x) - EDGE_W'(vtx.p2_x);
			a1_s1 <= EDGE_W'(vtx.p1_y) - EDGE_W'(vtx.p2_y);
			a2_s1 <= EDGE_W'(vtx.p1_z) - EDGE_W'(vtx.p2_z);
			b0_s1 <= EDGE_W'(vtx.p1_x) - EDGE_W'(vtx.p3_x);
			b1_s1 <= EDGE_W'(vtx.p1_y) - EDGE_W'(vtx.p3_y);
			b2_s1 <= EDGE_W'(vtx.p1_z) - EDGE_W'(vtx.p3_z);

			m0_s2 <= PROD_W'(a1_s1) * PROD_W'(b2_s1);
			m1_s2 <= PROD_W'(b1_s1) * PROD_W'(a2_s1);
			m2_s2 <= PROD_W'(b0_s1) * PROD_W'(a2_s1);
			m3_s2 <= PROD_W'(a0_s1) * PROD_W'(b2_s1);
			m4_s2 <= PROD_W'(a0_s1) * PROD_W'(b1_s1);
			m5_s2 <= PROD_W'(b0_s1) * PROD_W'(a1_s1);

			c0_s3 <= CROSS_W'(m0_s2) - CROSS_W'(m1_s2);
			c1_s3 <= CROSS_W'(m2_s2) - CROSS_W'(m3_s2);
			c2_s3 <= CROSS_W'(m4_s2) - CROSS_W'(m5_s2);

			side_s4.neg   <= {c2_s3[CROSS_W-1], c1_s3[CROSS_W-1], c0_s3[CROSS_W-1]};
			side_s4.mag[0] <= c0_s3[CROSS_W-1] ? MAG_W'(-c0_s3) : MAG_W'(c0_s3);
			side_s4.mag[1] <= c1_s3[CROSS_W-1] ? MAG_W'(-c1_s3) : MAG_W'(c1_s3);
			side_s4.mag[2] <= c2_s3[CROSS_W-1] ? MAG_W'(-c2_s3) : MAG_W'(c2_s3);
			side_s4.degen  <= (c0_s3 == '0) && (c1_s3 == '0) && (c2_s3 == '0);

			sq0_s5  <= SQ_W'(side_s4.mag[0]) * SQ_W'(side_s4.mag[0]);
			sq1_s5  <= SQ_W'(side_s4.mag[1]) * SQ_W'(side_s4.mag[1]);
			sq2_s5  <= SQ_W'(side_s4.mag[2]) * SQ_W'(side_s4.mag[2]);
			side_s5 <= side_s4;

			sum_s6  <= SUM_W'(sq0_s5) + SUM_W'(sq1_s5) + SUM_W'(sq2_s5);
			side_s6 <= side_s5;
		end
	end

	assign out_valid = v_s6;
	assign sum       = sum_s6;
	assign side      = side_s6;

endmodule

// ===== rtl/tun_sqrt.sv =====
module tun_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [tun_pkg::SUM_W-1:0]  sum,
	input  tun_pkg::side_t             side_in,
	output logic                       out_valid,
	output logic [tun_pkg::ROOT_W-1:0] root,
	output tun_pkg::side_t             side_out
);
	import tun_pkg::*;

	// One root bit per stage, most significant first.
	logic              v_s    [0:ROOT_W];
	logic [REM_W-1:0]  rem_s  [0:ROOT_W];
	logic [ROOT_W-1:0] root_s [0:ROOT_W];
	logic [SUM_W-1:0]  opnd_s [0:ROOT_W];
	side_t             side_s [0:ROOT_W];

	assign v_s[0]    = in_valid;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign opnd_s[0] = sum;
	assign side_s[0] = side_in;

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		logic [REM_W-1:0] rem_sh, trial, rem_nx;
		logic             ge;

		always_comb begin
			rem_sh = {rem_s[k][REM_W-3:0], opnd_s[k][SUM_W-1 -: 2]};
			trial  = {root_s[k], 2'b01};
			ge     = rem_sh >= trial;
			rem_nx = ge ? rem_sh - trial : rem_sh;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= rem_nx;
				root_s[k+1] <= {root_s[k][ROOT_W-2:0], ge};
				opnd_s[k+1] <= {opnd_s[k][SUM_W-3:0], 2'b00};
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = v_s[ROOT_W];
	assign root      = root_s[ROOT_W];
	assign side_out  = side_s[ROOT_W];

endmodule

// ===== rtl/tun_div.sv =====
module tun_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [tun_pkg::ROOT_W-1:0] root,
	input  logic [tun_pkg::MAG_W-1:0]  mag,
	input  logic                       neg,
	input  logic                       zero,
	output logic                       out_valid,
	output tun_pkg::lane_t             lane
);
	import tun_pkg::*;

	// The magnitude never exceeds the root, so the first quotient bit is the
	// only one that can weigh in at one whole unit.
	logic              v_s    [0:QUOT_W];
	logic [DREM_W-1:0] rem_s  [0:QUOT_W];
	logic [QUOT_W-1:0] q_s    [0:QUOT_W];
	logic [ROOT_W-1:0] d_s    [0:QUOT_W];
	logic              neg_s  [0:QUOT_W];
	logic              zero_s [0:QUOT_W];
	logic              v_q;
	lane_t             lane_q;

	assign v_s[0]    = in_valid;
	assign rem_s[0]  = DREM_W'(mag);
	assign q_s[0]    = '0;
	assign d_s[0]    = root;
	assign neg_s[0]  = neg;
	assign zero_s[0] = zero;

	for (genvar j = 0; j < QUOT_W; j++) begin : g_stage
		logic [DREM_W-1:0] rem_x;
		logic              ge;

		always_comb begin
			if (j == 0) begin
				rem_x = rem_s[j];
			end else begin
				rem_x = {rem_s[j][DREM_W-2:0], 1'b0};
			end
			ge = rem_x >= DREM_W'(d_s[j]);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (en) begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1]  <= ge ? rem_x - DREM_W'(d_s[j]) : rem_x;
				q_s[j+1]    <= {q_s[j][QUOT_W-2:0], ge};
				d_s[j+1]    <= d_s[j];
				neg_s[j+1]  <= neg_s[j];
				zero_s[j+1] <= zero_s[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_s[QUOT_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_q.zero <= zero_s[QUOT_W];
			if (zero_s[QUOT_W]) begin
				lane_q.value <= '0;
			end else if (neg_s[QUOT_W]) begin
				lane_q.value <= -$signed(OUT_W'(q_s[QUOT_W]));
			end else begin
				lane_q.value <= $signed(OUT_W'(q_s[QUOT_W]));
			end
		end
	end

	assign out_valid = v_q;
	assign lane      = lane_q;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;

	import tun_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic vtx_valid = 1'b0;
	logic vtx_stall;
	in_t vtx = '0;
	logic nrm_valid;
	logic nrm_stall = 1'b0;
	out_t nrm;

	out_t normals_due[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_off = 1'b0;

	triangle_unit_normal_top uut (
		.clk(clk), .arst_n(arst_n),
		.vtx_valid(vtx_valid), .vtx_stall(vtx_stall), .vtx(vtx),
		.nrm_valid(nrm_valid), .nrm_stall(nrm_stall), .nrm(nrm)
	);

	always #2 clk = ~clk;

	// Exact floor square root of a value below 2^104.
	function automatic logic [63:0] floor_root(logic [127:0] s);
		logic [63:0] r;
		logic [63:0] t;
		r = '0;
		for (int b = 52; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (128'(t) * 128'(t) <= s)
				r = t;
		end
		return r;
	endfunction

	function automatic logic signed [OUT_W-1:0] unit_component(logic signed [63:0] c,
			logic [63:0] r);
		logic [127:0] q;
		logic [63:0] m;
		m = (c < 0) ? 64'(-c) : 64'(c);
		q = (128'(m) << NORMAL_FRAC_BITS) / 128'(r);
		if (q > (128'd1 << NORMAL_FRAC_BITS))
			q = 128'd1 << NORMAL_FRAC_BITS;
		return (c < 0) ? -OUT_W'(q) : OUT_W'(q);
	endfunction

	function automatic out_t triangle_normal(in_t t);
		logic signed [63:0] ax, ay, az, bx, by, bz, cx, cy, cz;
		logic [127:0] s;
		logic [63:0] r;
		out_t o;
		ax = 64'(t.p1_x) - 64'(t.p2_x);
		ay = 64'(t.p1_y) - 64'(t.p2_y);
		az = 64'(t.p1_z) - 64'(t.p2_z);
		bx = 64'(t.p1_x) - 64'(t.p3_x);
		by = 64'(t.p1_y) - 64'(t.p3_y);
		bz = 64'(t.p1_z) - 64'(t.p3_z);
		cx = ay * bz - by * az;
		cy = bx * az - ax * bz;
		cz = ax * by - bx * ay;
		o = '0;
		if (cx == 0 && cy == 0 && cz == 0) begin
			o.degenerate = 1'b1;
			return o;
		end
		// The squares can pass 2^64, so they are formed at full width.
		s = 128'(cx) * 128'(cx) + 128'(cy) * 128'(cy) + 128'(cz) * 128'(cz);
		r = floor_root(s);
		o.normal_x = unit_component(cx, r);
		o.normal_y = unit_component(cy, r);
		o.normal_z = unit_component(cz, r);
		return o;
	endfunction

	// Called at a falling edge; returns at the falling edge after the transaction,
	// with valid still high so that the next transaction can follow at once.
	task automatic send_triangle(in_t t);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			vtx_valid <= 1'b0;
			@(negedge clk);
		end
		vtx <= t;
		vtx_valid <= 1'b1;
		@(posedge clk);
		while (vtx_stall)
			@(posedge clk);
		normals_due.push_back(triangle_normal(t));
		@(negedge clk);
	endtask

	function automatic logic [15:0] rand_coord(int span);
		if (span >= 16)
			return 16'($urandom);
		return 16'($urandom_range(0, (1 << span) - 1) - (1 << (span - 1)));
	endfunction

	function automatic in_t random_triangle();
		in_t t;
		int span;
		span = $urandom_range(2, 16);
		t.p1_x = rand_coord(span); t.p1_y = rand_coord(span); t.p1_z = rand_coord(span);
		t.p2_x = rand_coord(span); t.p2_y = rand_coord(span); t.p2_z = rand_coord(span);
		t.p3_x = rand_coord(span); t.p3_y = rand_coord(span); t.p3_z = rand_coord(span);
		// Now and then make the vertices collinear or coincident.
		if ($urandom_range(15) == 0) begin
			t.p3_x = t.p1_x;
			t.p3_y = t.p1_y;
			t.p3_z = t.p1_z;
		end
		if ($urandom_range(15) == 0) begin
			t.p2_x = t.p1_x;
			t.p2_y = t.p1_y;
			t.p2_z = t.p1_z;
		end
		return t;
	endfunction

	always @(negedge clk) begin
		if (hold_off)
			nrm_stall <= 1'b1;
		else
			nrm_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && nrm_valid && !nrm_stall) begin
			if (normals_due.size() == 0) begin
				$display("%0t: unexpected normal %h", $time, nrm);
				errors++;
			end else begin
				if (nrm !== normals_due[0]) begin
					$display({"%0t: normal expected x %0d y %0d z %0d deg %0b, ",
						"got x %0d y %0d z %0d deg %0b"},
						$time, normals_due[0].normal_x, normals_due[0].normal_y,
						normals_due[0].normal_z, normals_due[0].degenerate,
						nrm.normal_x, nrm.normal_y, nrm.normal_z, nrm.degenerate);
					errors++;
				end
				void'(normals_due.pop_front());
			end
		end
	end

	task automatic test_directed();
		in_t t;
		t = '0;
		send_triangle(t);
		t = '0; t.p2_x = 16'sd256; t.p3_y = 16'sd256;
		send_triangle(t);
		t = '0; t.p2_y = 16'sd256; t.p3_z = 16'sd256;
		send_triangle(t);
		t = '0; t.p2_z = 16'sd256; t.p3_x = 16'sd256;
		send_triangle(t);
		t = '0; t.p2_x = 16'sd256; t.p3_x = -16'sd512;
		send_triangle(t);
		t = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000,
			16'h8000, 16'h7fff, 16'h8000};
		send_triangle(t);
		t = '{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
			16'h8000, 16'h7fff, 16'h8000};
		send_triangle(t);
		t = '{16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
			16'h7fff, 16'h7fff, 16'h8000};
		send_triangle(t);
		t = '{16'hffff, 16'hffff, 16'hffff, 16'h0000, 16'h0000, 16'h0000,
			16'hffff, 16'h0000, 16'h0001};
		send_triangle(t);
		t = '{16'h0001, 16'h0, 16'h0, 16'h0, 16'h0001, 16'h0, 16'h0, 16'h0, 16'h0001};
		send_triangle(t);
		t = '{16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa,
			16'h1234, 16'hedcb, 16'h0f0f};
		send_triangle(t);
		t = '{16'h1234, 16'h1234, 16'h1234, 16'h1234, 16'h1234, 16'h1234,
			16'h1234, 16'h1234, 16'h1234};
		send_triangle(t);
	endtask

	task automatic test_random_phase(int count, int idle_pct, int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count)
			send_triangle(random_triangle());
	endtask

	task automatic test_backpressure();
		hold_off = 1'b1;
		fork
			begin
				repeat (200)
					@(posedge clk);
				hold_off = 1'b0;
			end
			repeat (100)
				send_triangle(random_triangle());
		join
	endtask

	initial begin
		repeat (2)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random_phase(110, 0, 0);
		test_random_phase(90, 47, 0);
		test_random_phase(90, 0, 47);
		test_random_phase(90, 31, 31);
		test_backpressure();
		test_random_phase(60, 0, 0);
		vtx_valid <= 1'b0;
		recv_stall_pct = 0;
		wait (normals_due.size() == 0);
		repeat (80)
			@(posedge clk);
		if (errors == 0 && normals_due.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
